### design/mfpg_pkg.sv
// mfpg_pkg: shared types, codes, tables and fixed-point helpers for the MLP unit.
// No dependencies; imported by every module of the block.
package mfpg_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned AccW     = 40;
  localparam int unsigned FracBits = 12;
  localparam int unsigned ParAw    = 10;
  localparam int unsigned ActAw    = 6;
  localparam int unsigned GradAw   = 14;
  localparam int unsigned WIdxW    = 4;
  localparam int unsigned WCntW    = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;

  localparam logic signed [WordW-1:0] OneWord = 16'sd4096;

  // commands of one input item
  localparam logic [1:0] CmdWrite  = 2'd0;
  localparam logic [1:0] CmdLoad   = 2'd1;
  localparam logic [1:0] CmdRdOut  = 2'd2;
  localparam logic [1:0] CmdRdGrad = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumLayers = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth0    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWidth1    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWidth2    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWidth3    = 3'd4;

  // datapath select codes
  localparam logic [1:0] WselIn    = 2'd0;
  localparam logic [1:0] WselWord  = 2'd1;
  localparam logic [1:0] WselTanh  = 2'd2;
  localparam logic       DerOne    = 1'b0;
  localparam logic       DerLut    = 1'b1;
  localparam logic [1:0] MulActPar = 2'd0;
  localparam logic [1:0] MulBvDer  = 2'd1;
  localparam logic [1:0] MulTjAct  = 2'd2;
  localparam logic [1:0] MulTjPar  = 2'd3;
  localparam logic [1:0] AccNone   = 2'd0;
  localparam logic [1:0] AccClr    = 2'd1;
  localparam logic [1:0] AccProd   = 2'd2;
  localparam logic [1:0] AccBias   = 2'd3;
  localparam logic       SrcAcc    = 1'b0;
  localparam logic       SrcProd   = 1'b1;
  localparam logic       LutTanh   = 1'b0;
  localparam logic       LutDtanh  = 1'b1;
  localparam logic       OutAct    = 1'b0;
  localparam logic       OutGrad   = 1'b1;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ParAw-1:0]        param_index;
    logic [WIdxW-1:0]        elem_index;
    logic signed [WordW-1:0] value;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] read_value;
    logic                    is_read;
  } out_t;

  typedef struct packed {
    logic [2:0]                  nl;
    logic [3:0][WCntW-1:0]       w;
    logic [3:0][ParAw-1:0]       offw;
    logic [3:0][ParAw-1:0]       offb;
    logic [WCntW-1:0]            wout;
    logic [ParAw-1:0]            npar;
  } geom_t;

  typedef struct packed {
    logic              par_we;
    logic              par_re;
    logic [ParAw-1:0]  par_addr;
    logic              act_we;
    logic              act_re;
    logic [1:0]        act_wsel;
    logic [ActAw-1:0]  act_addr;
    logic              der_we;
    logic              der_re;
    logic              der_wsel;
    logic [ActAw-1:0]  der_addr;
    logic              grad_we;
    logic              grad_re;
    logic [GradAw-1:0] grad_addr;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic [1:0]        acc_op;
    logic              word_en;
    logic              word_src;
    logic              lut_en;
    logic              lut_sel;
    logic [WIdxW-1:0]  vidx;
    logic [WIdxW-1:0]  iidx;
    logic              bv_init;
    logic              bv_we;
    logic              tj_we;
    logic              out_load;
    logic              out_isrd;
    logic              out_src;
  } dp_cmd_t;

  // tanh in Q16 and its derivative in Q15, sampled at x = 0, 0.25, ... 4
  localparam logic [15:0] TanhTab [17] = '{
    16'd0, 16'd16051, 16'd30285, 16'd41625, 16'd49912, 16'd55593, 16'd59320,
    16'd61694, 16'd63178, 16'd64096, 16'd64659, 16'd65000, 16'd65212,
    16'd65339, 16'd65417, 16'd65463, 16'd65492};
  localparam logic [15:0] DtanhTab [17] = '{
    16'd32768, 16'd30802, 16'd25770, 16'd19549, 16'd13762, 16'd9189,
    16'd5921, 16'd3729, 16'd2312, 16'd1425, 16'd871, 16'd534, 16'd323,
    16'd196, 16'd119, 16'd72, 16'd44};

  // saturating 40-bit add
  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                     input logic signed [AccW-1:0] b);
    logic signed [AccW:0] r;
    r = {a[AccW-1], a} + {b[AccW-1], b};
    if (r[AccW] != r[AccW-1]) begin
      return r[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return r[AccW-1:0];
  endfunction

  // round half up to a word, then saturate
  function automatic logic signed [WordW-1:0] to_word(input logic signed [AccW-1:0] a);
    logic signed [AccW:0]          r;
    logic signed [AccW-FracBits:0] s;
    r = {a[AccW-1], a} + (AccW+1)'(1 << (FracBits - 1));
    s = r[AccW:FracBits];
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return s[WordW-1:0];
  endfunction

  // interpolated table value of |x|
  function automatic logic [WordW-1:0] lut(input logic signed [WordW-1:0] x,
                                            input logic sel);
    logic [WordW:0]  a;
    logic [5:0]      seg;
    logic [10:0]     f;
    logic [15:0]     t0;
    logic [15:0]     t1;
    logic [28:0]     num;
    a   = x[WordW-1] ? (17'd0 - {1'b1, x}) : {1'b0, x};
    seg = a[16:11];
    f   = a[10:0];
    if (seg >= 6'd16) begin
      t0  = sel ? DtanhTab[16] : TanhTab[16];
      num = 29'(t0) << 11;
    end else begin
      t0  = sel ? DtanhTab[seg[3:0]] : TanhTab[seg[3:0]];
      t1  = sel ? DtanhTab[5'(seg[3:0]) + 5'd1] : TanhTab[5'(seg[3:0]) + 5'd1];
      num = 29'(t0) * 29'(12'd2048 - 12'(f)) + 29'(t1) * 29'(f);
    end
    num = num + 29'd16384;
    return 16'(num >> 15);
  endfunction

endpackage

### design/mlp_forward_and_param_gradient_unit.sv
// Top level of the MLP forward/gradient unit: geometry, sequencer and datapath.
// Depends on mfpg_pkg, mfpg_geom, mfpg_ctrl, mfpg_dp.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i/in_ready_o   in_data_i (mfpg_pkg::in_t)
//   out      out        out_valid_o/out_ready_i out_data_o (mfpg_pkg::out_t)
//
// Every input transfer yields one output transfer, held first in a pending register
// and then in the output register; writes, loads and reads take one item per cycle
// while the output is not stalled. A load marked last holds in_ready_o low for the
// passes: a forward pass over all layers, then one backward pass per output element.
// The shared multiplier and one read port per memory set the length of the passes.
// Reset is asynchronous active low; memories are not cleared, no clearing pass.
// A stalled output holds its result; one more item may be accepted behind it.
module mlp_forward_and_param_gradient_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mfpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mfpg_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mfpg_pkg::out_t                 out_data_o
);
  import mfpg_pkg::*;

  geom_t   geom;
  dp_cmd_t dp_cmd;

  // config registers and layer offsets
  mfpg_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  // sequencer: command decode, pass loops, result handshake
  mfpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  // memories and arithmetic
  mfpg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_value_i (in_data_i.value),
    .out_data_o (out_data_o)
  );

endmodule

### design/mfpg_geom.sv
// mfpg_geom: configuration registers and derived layer geometry (clamped widths,
// packed parameter offsets, parameter count). Depends on mfpg_pkg.
module mfpg_geom (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mfpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output mfpg_pkg::geom_t                geom_o
);
  import mfpg_pkg::*;

  logic [2:0]       nl_q;
  logic [WCntW-1:0] w_q [4];
  logic [WCntW-1:0] wc  [4];
  logic [2:0]       nlc;
  logic [1:0]       top_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q   <= 3'd3;
      w_q[0] <= 5'd4;
      w_q[1] <= 5'd8;
      w_q[2] <= 5'd1;
      w_q[3] <= 5'd1;
    end else if (cfg_we_i) begin
      priority case (cfg_idx_i)
        CfgNumLayers: nl_q   <= cfg_wdata_i[2:0];
        CfgWidth0:    w_q[0] <= cfg_wdata_i;
        CfgWidth1:    w_q[1] <= cfg_wdata_i;
        CfgWidth2:    w_q[2] <= cfg_wdata_i;
        CfgWidth3:    w_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    nlc = (nl_q < 3'd2) ? 3'd2 : ((nl_q > 3'd4) ? 3'd4 : nl_q);
    for (int e = 0; e < 4; e++) begin
      wc[e] = (w_q[e] == 5'd0) ? 5'd1 : ((w_q[e] > 5'd16) ? 5'd16 : w_q[e]);
      geom_o.w[e] = wc[e];
    end
    geom_o.nl      = nlc;
    geom_o.offw[0] = '0;
    geom_o.offb[3] = '0;
    for (int t = 0; t < 3; t++) begin
      geom_o.offb[t]   = geom_o.offw[t] + 10'(wc[t+1]) * 10'(wc[t]);
      geom_o.offw[t+1] = geom_o.offb[t] + 10'(wc[t+1]);
    end
    top_idx      = 2'(nlc - 3'd1);
    geom_o.wout  = wc[top_idx];
    geom_o.npar  = geom_o.offw[top_idx];
  end

endmodule

### design/mfpg_dp.sv
// mfpg_dp: datapath - parameter, activation, derivative and gradient memories,
// shared multiplier, saturating accumulator, table unit, output register.
// Depends on mfpg_pkg; driven by mfpg_ctrl commands.
module mfpg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mfpg_pkg::dp_cmd_t                 cmd_i,
  input  logic signed [mfpg_pkg::WordW-1:0] in_value_i,
  output mfpg_pkg::out_t                    out_data_o
);
  import mfpg_pkg::*;

  logic signed [WordW-1:0] par_mem  [1024];
  logic signed [WordW-1:0] act_mem  [64];
  logic signed [WordW-1:0] der_mem  [64];
  logic signed [WordW-1:0] grad_mem [16384];

  logic signed [WordW-1:0] par_rd_q, act_rd_q, der_rd_q, grad_rd_q;
  logic signed [WordW-1:0] bv_q [16];
  logic signed [WordW-1:0] tj_q [16];
  logic signed [WordW-1:0] mul_a, mul_b;
  logic signed [31:0]      prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [WordW-1:0] word_q;
  logic [WordW-1:0]        lut_q;
  logic signed [WordW-1:0] act_wdata, der_wdata;
  logic signed [AccW-1:0]  prod_ext, bias_ext;
  out_t                    out_q;

  assign prod_ext = {{(AccW-32){prod_q[31]}}, prod_q};
  assign bias_ext = {{(AccW-WordW-FracBits){par_rd_q[WordW-1]}}, par_rd_q,
                     {FracBits{1'b0}}};

  always_comb begin
    unique case (cmd_i.mul_sel)
      MulActPar: begin mul_a = act_rd_q;          mul_b = par_rd_q; end
      MulBvDer:  begin mul_a = bv_q[cmd_i.vidx];  mul_b = der_rd_q; end
      MulTjAct:  begin mul_a = tj_q[cmd_i.vidx];  mul_b = act_rd_q; end
      default:   begin mul_a = tj_q[cmd_i.vidx];  mul_b = par_rd_q; end
    endcase
    unique case (cmd_i.act_wsel)
      WselIn:   act_wdata = in_value_i;
      WselWord: act_wdata = word_q;
      WselTanh: act_wdata = word_q[WordW-1] ? -$signed(lut_q) : $signed(lut_q);
      default:  act_wdata = word_q;
    endcase
    der_wdata = (cmd_i.der_wsel == DerLut) ? $signed(lut_q) : OneWord;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.par_we) par_mem[cmd_i.par_addr] <= in_value_i;
    if (cmd_i.par_re) par_rd_q <= par_mem[cmd_i.par_addr];
    if (cmd_i.act_we) act_mem[cmd_i.act_addr] <= act_wdata;
    if (cmd_i.act_re) act_rd_q <= act_mem[cmd_i.act_addr];
    if (cmd_i.der_we) der_mem[cmd_i.der_addr] <= der_wdata;
    if (cmd_i.der_re) der_rd_q <= der_mem[cmd_i.der_addr];
    if (cmd_i.grad_we) grad_mem[cmd_i.grad_addr] <= word_q;
    if (cmd_i.grad_re) grad_rd_q <= grad_mem[cmd_i.grad_addr];
  end

  // arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    unique case (cmd_i.acc_op)
      AccClr:  acc_q <= '0;
      AccProd: acc_q <= sat_add(acc_q, prod_ext);
      AccBias: acc_q <= sat_add(acc_q, bias_ext);
      default: ;
    endcase
    if (cmd_i.word_en) word_q <= to_word((cmd_i.word_src == SrcProd) ? prod_ext : acc_q);
    if (cmd_i.lut_en) lut_q <= lut(word_q, cmd_i.lut_sel);
    if (cmd_i.tj_we) tj_q[cmd_i.vidx] <= word_q;
    if (cmd_i.out_load) begin
      out_q.is_read    <= cmd_i.out_isrd;
      out_q.read_value <= !cmd_i.out_isrd ? '0 :
                          ((cmd_i.out_src == OutGrad) ? grad_rd_q : act_rd_q);
    end
  end

  // backprop vector, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 16; e++) bv_q[e] <= '0;
    end else if (cmd_i.bv_init) begin
      for (int e = 0; e < 16; e++) bv_q[e] <= (4'(e) == cmd_i.iidx) ? OneWord : '0;
    end else if (cmd_i.bv_we) begin
      bv_q[cmd_i.vidx] <= word_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### design/mfpg_ctrl.sv
// mfpg_ctrl: sequencer for command handling, forward and backward passes, and
// the result pending/output handshake. Depends on mfpg_pkg; drives mfpg_dp.
module mfpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfpg_pkg::geom_t   geom_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mfpg_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfpg_pkg::dp_cmd_t cmd_o
);
  import mfpg_pkg::*;

  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SFinit  = 5'd1;
  localparam logic [4:0] SFneu   = 5'd2;
  localparam logic [4:0] SFrd    = 5'd3;
  localparam logic [4:0] SFmul   = 5'd4;
  localparam logic [4:0] SFacc   = 5'd5;
  localparam logic [4:0] SFbrd   = 5'd6;
  localparam logic [4:0] SFbacc  = 5'd7;
  localparam logic [4:0] SFword  = 5'd8;
  localparam logic [4:0] SFwout  = 5'd9;
  localparam logic [4:0] SFlut   = 5'd10;
  localparam logic [4:0] SFwt    = 5'd11;
  localparam logic [4:0] SFwd    = 5'd12;
  localparam logic [4:0] SBinit  = 5'd13;
  localparam logic [4:0] SBtrd   = 5'd14;
  localparam logic [4:0] SBtmul  = 5'd15;
  localparam logic [4:0] SBtword = 5'd16;
  localparam logic [4:0] SBtw    = 5'd17;
  localparam logic [4:0] SBgrd   = 5'd18;
  localparam logic [4:0] SBgmul  = 5'd19;
  localparam logic [4:0] SBgword = 5'd20;
  localparam logic [4:0] SBgw    = 5'd21;
  localparam logic [4:0] SBpclr  = 5'd22;
  localparam logic [4:0] SBprd   = 5'd23;
  localparam logic [4:0] SBpmul  = 5'd24;
  localparam logic [4:0] SBpacc  = 5'd25;
  localparam logic [4:0] SBpword = 5'd26;
  localparam logic [4:0] SBpw    = 5'd27;

  logic [4:0]       state_q, state_d;
  logic [1:0]       lay_q, lay_d;
  logic [WCntW-1:0] j_q, j_d, k_q, k_d, i_q, i_d;
  logic             pend_q, pend_d, pend_isrd_q, pend_isrd_d, pend_src_q, pend_src_d;
  logic             out_valid_q, out_valid_d;

  logic             adv, in_fire, fwd_next;
  logic [1:0]       t_idx, nlm1;
  logic [WCntW-1:0] wt, wl;
  logic [ParAw-1:0] wj, pw, pb;
  logic             lastk, lastj, lasti, lastk0, last_layer;
  logic             rd_out_ok, rd_grad_ok;

  assign t_idx      = lay_q - 2'd1;
  assign nlm1       = 2'(geom_i.nl - 3'd1);
  assign wt         = geom_i.w[t_idx];
  assign wl         = geom_i.w[lay_q];
  assign wj         = 10'(wt) * 10'(j_q);
  assign pw         = geom_i.offw[t_idx] + 10'(k_q) + wj;
  assign pb         = geom_i.offb[t_idx] + 10'(j_q);
  assign lastk      = (k_q + 5'd1) == wt;
  assign lastj      = (j_q + 5'd1) == wl;
  assign lasti      = (i_q + 5'd1) == geom_i.wout;
  assign lastk0     = (k_q + 5'd1) == geom_i.w[0];
  assign last_layer = ({1'b0, lay_q} + 3'd1) == geom_i.nl;
  assign rd_out_ok  = {1'b0, in_data_i.elem_index} < geom_i.wout;
  assign rd_grad_ok = rd_out_ok && (in_data_i.param_index < geom_i.npar);

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && (!pend_q || adv);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    lay_d       = lay_q;
    j_d         = j_q;
    k_d         = k_q;
    i_d         = i_q;
    fwd_next    = 1'b0;
    cmd_o.vidx  = j_q[WIdxW-1:0];
    cmd_o.iidx  = i_q[WIdxW-1:0];

    // result stage
    cmd_o.out_load = adv && pend_q;
    cmd_o.out_isrd = pend_isrd_q;
    cmd_o.out_src  = pend_src_q;
    out_valid_d    = adv ? pend_q : out_valid_q;
    pend_d         = in_fire ? 1'b1 : (adv ? 1'b0 : pend_q);
    pend_isrd_d    = pend_isrd_q;
    pend_src_d     = pend_src_q;

    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          pend_isrd_d = 1'b0;
          pend_src_d  = OutAct;
          unique case (in_data_i.cmd)
            CmdWrite: begin
              cmd_o.par_we   = 1'b1;
              cmd_o.par_addr = in_data_i.param_index;
            end
            CmdLoad: begin
              cmd_o.act_we   = 1'b1;
              cmd_o.act_wsel = WselIn;
              cmd_o.act_addr = {2'b00, in_data_i.elem_index};
              if (in_data_i.last) begin
                k_d     = '0;
                state_d = SFinit;
              end
            end
            CmdRdOut: begin
              cmd_o.act_re   = 1'b1;
              cmd_o.act_addr = {nlm1, in_data_i.elem_index};
              pend_isrd_d    = rd_out_ok;
            end
            default: begin
              cmd_o.grad_re   = 1'b1;
              cmd_o.grad_addr = {in_data_i.elem_index, in_data_i.param_index};
              pend_isrd_d     = rd_grad_ok;
              pend_src_d      = OutGrad;
            end
          endcase
        end
      end
      // input layer derivatives are 1.0
      SFinit: begin
        cmd_o.der_we   = 1'b1;
        cmd_o.der_wsel = DerOne;
        cmd_o.der_addr = {2'b00, k_q[WIdxW-1:0]};
        k_d = k_q + 5'd1;
        if (lastk0) begin
          lay_d   = 2'd1;
          j_d     = '0;
          state_d = SFneu;
        end
      end
      SFneu: begin
        cmd_o.acc_op = AccClr;
        k_d     = '0;
        state_d = SFrd;
      end
      SFrd: begin
        cmd_o.act_re   = 1'b1;
        cmd_o.act_addr = {t_idx, k_q[WIdxW-1:0]};
        cmd_o.par_re   = 1'b1;
        cmd_o.par_addr = pw;
        state_d = SFmul;
      end
      SFmul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulActPar;
        state_d = SFacc;
      end
      SFacc: begin
        cmd_o.acc_op = AccProd;
        k_d     = k_q + 5'd1;
        state_d = lastk ? SFbrd : SFrd;
      end
      SFbrd: begin
        cmd_o.par_re   = 1'b1;
        cmd_o.par_addr = pb;
        state_d = SFbacc;
      end
      SFbacc: begin
        cmd_o.acc_op = AccBias;
        state_d = SFword;
      end
      SFword: begin
        cmd_o.word_en  = 1'b1;
        cmd_o.word_src = SrcAcc;
        state_d = last_layer ? SFwout : SFlut;
      end
      SFwout: begin
        cmd_o.act_we   = 1'b1;
        cmd_o.act_wsel = WselWord;
        cmd_o.act_addr = {lay_q, j_q[WIdxW-1:0]};
        cmd_o.der_we   = 1'b1;
        cmd_o.der_wsel = DerOne;
        cmd_o.der_addr = {lay_q, j_q[WIdxW-1:0]};
        fwd_next = 1'b1;
      end
      SFlut: begin
        cmd_o.lut_en  = 1'b1;
        cmd_o.lut_sel = LutTanh;
        state_d = SFwt;
      end
      SFwt: begin
        cmd_o.act_we   = 1'b1;
        cmd_o.act_wsel = WselTanh;
        cmd_o.act_addr = {lay_q, j_q[WIdxW-1:0]};
        cmd_o.lut_en   = 1'b1;
        cmd_o.lut_sel  = LutDtanh;
        state_d = SFwd;
      end
      SFwd: begin
        cmd_o.der_we   = 1'b1;
        cmd_o.der_wsel = DerLut;
        cmd_o.der_addr = {lay_q, j_q[WIdxW-1:0]};
        fwd_next = 1'b1;
      end
      SBinit: begin
        cmd_o.bv_init = 1'b1;
        lay_d   = nlm1;
        j_d     = '0;
        state_d = SBtrd;
      end
      SBtrd: begin
        cmd_o.der_re   = 1'b1;
        cmd_o.der_addr = {lay_q, j_q[WIdxW-1:0]};
        state_d = SBtmul;
      end
      SBtmul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulBvDer;
        state_d = SBtword;
      end
      SBtword: begin
        cmd_o.word_en  = 1'b1;
        cmd_o.word_src = SrcProd;
        state_d = SBtw;
      end
      SBtw: begin
        cmd_o.tj_we     = 1'b1;
        cmd_o.grad_we   = 1'b1;
        cmd_o.grad_addr = {i_q[WIdxW-1:0], pb};
        k_d     = '0;
        state_d = SBgrd;
      end
      SBgrd: begin
        cmd_o.act_re   = 1'b1;
        cmd_o.act_addr = {t_idx, k_q[WIdxW-1:0]};
        state_d = SBgmul;
      end
      SBgmul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulTjAct;
        state_d = SBgword;
      end
      SBgword: begin
        cmd_o.word_en  = 1'b1;
        cmd_o.word_src = SrcProd;
        state_d = SBgw;
      end
      SBgw: begin
        cmd_o.grad_we   = 1'b1;
        cmd_o.grad_addr = {i_q[WIdxW-1:0], pw};
        if (lastk) begin
          k_d = '0;
          if (lastj) begin
            j_d     = '0;
            state_d = SBpclr;
          end else begin
            j_d     = j_q + 5'd1;
            state_d = SBtrd;
          end
        end else begin
          k_d     = k_q + 5'd1;
          state_d = SBgrd;
        end
      end
      SBpclr: begin
        cmd_o.acc_op = AccClr;
        j_d     = '0;
        state_d = SBprd;
      end
      SBprd: begin
        cmd_o.par_re   = 1'b1;
        cmd_o.par_addr = pw;
        state_d = SBpmul;
      end
      SBpmul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulTjPar;
        state_d = SBpacc;
      end
      SBpacc: begin
        cmd_o.acc_op = AccProd;
        if (lastj) begin
          state_d = SBpword;
        end else begin
          j_d     = j_q + 5'd1;
          state_d = SBprd;
        end
      end
      SBpword: begin
        cmd_o.word_en  = 1'b1;
        cmd_o.word_src = SrcAcc;
        state_d = SBpw;
      end
      SBpw: begin
        cmd_o.bv_we = 1'b1;
        cmd_o.vidx  = k_q[WIdxW-1:0];
        if (lastk) begin
          k_d = '0;
          if (lay_q == 2'd1) begin
            if (lasti) begin
              state_d = SIdle;
            end else begin
              i_d     = i_q + 5'd1;
              state_d = SBinit;
            end
          end else begin
            lay_d   = lay_q - 2'd1;
            j_d     = '0;
            state_d = SBtrd;
          end
        end else begin
          k_d     = k_q + 5'd1;
          state_d = SBpclr;
        end
      end
      default: state_d = SIdle;
    endcase

    // advance to the next forward neuron, layer, or the backward pass
    if (fwd_next) begin
      if (lastj) begin
        j_d = '0;
        if (last_layer) begin
          i_d     = '0;
          state_d = SBinit;
        end else begin
          lay_d   = lay_q + 2'd1;
          state_d = SFneu;
        end
      end else begin
        j_d     = j_q + 5'd1;
        state_d = SFneu;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      lay_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      pend_q      <= 1'b0;
      pend_isrd_q <= 1'b0;
      pend_src_q  <= OutAct;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lay_q       <= lay_d;
      j_q         <= j_d;
      k_q         <= k_d;
      i_q         <= i_d;
      pend_q      <= pend_d;
      pend_isrd_q <= pend_isrd_d;
      pend_src_q  <= pend_src_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### design/mfpg_checker.sv
// mfpg_checker: port-level assertions for the MLP unit, bound to the top level.
// Depends on mfpg_pkg.
module mfpg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input mfpg_pkg::in_t                  in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input mfpg_pkg::out_t                 out_data_o
);
  import mfpg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_no_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_read |-> out_data_o.read_value == '0)
    else $error("non-read result carries data");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result after input transfer");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == CmdLoad && in_data_i.last
    |=> !in_ready_o)
    else $error("accepting during evaluation");

endmodule

bind mlp_forward_and_param_gradient_unit mfpg_checker u_mfpg_checker (.*);
